@@ sv/sbht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral band history tracker package
// Field widths, register map and controller states shared by the block.
// ----------------------------------------------------------------------------
package sbht_pkg;

   localparam int MAG_W      = 25;  // bin magnitude, band level, history mean
   localparam int IDX_W      = 9;   // bin index within a frame
   localparam int BAND_OUT_W = 7;   // band index on the result channel
   localparam int ACC_W      = 27;  // band accumulator, wraps at this width
   localparam int LEN_W      = 7;   // history length register
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [LEN_W-1:0] HISTORY_LEN_RESET = 7'd43;

   // Register index as decoded from the word address.
   localparam logic CSR_IDX_HISTORY_LEN = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ACCUM,
      ST_DIV_LEVEL,
      ST_UPDATE,
      ST_DIV_MEAN
   } sbht_state_type;

endpackage

@@ sv/spectral_band_history_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral band history tracker
// Averages groups of FFT magnitude bins into band levels and keeps a ring of
// recent levels per band, reporting each new level with its history mean.
// ----------------------------------------------------------------------------
// Flow: the input takes no new bin until the last one is through. A bin that
// leaves its band open passes decode and accumulate. A bin that closes a band
// also passes the level step, the sum update and the serial divider for the
// history mean; its result word is registered, after any stalled one is taken.
// Reset: synchronous, active high. History length returns to 43; fill count,
// ring slot, accumulator and the per-band sum valid flags clear, so sums read 0.
// ----------------------------------------------------------------------------
module spectral_band_history_tracker
   import sbht_pkg::*;
#(
   parameter int BANDS         = 128,
   parameter int BINS_PER_BAND = 4,
   parameter int MAX_HISTORY   = 64
) (
   input  logic                    clock,
   input  logic                    reset,

   // Bin words in.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [MAG_W-1:0]        req_bin_magnitude,
   input  logic [IDX_W-1:0]        req_bin_index,

   // Band result words out.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [BAND_OUT_W-1:0]   rsp_band_index,
   output logic [MAG_W-1:0]        rsp_band_level,
   output logic [MAG_W-1:0]        rsp_history_mean,
   output logic                    rsp_frame_done,

   // Register port.
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   // Band number comes from a reciprocal multiply. With a 9-bit index and a
   // divisor of at most 16 the error term stays far below one quotient step.
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP       = (1 << RECIP_SHIFT) / BINS_PER_BAND + 1;

   // The band level is the accumulator over the bin count, also taken by a
   // reciprocal multiply. A 27-bit accumulator against a 31-bit shift keeps
   // the error below one part in sixteen of a quotient step, so it is exact.
   localparam int               LEVEL_SHIFT = 31;
   localparam logic [31:0]      LEVEL_RECIP =
      32'((64'd1 << LEVEL_SHIFT) / BINS_PER_BAND + 1);
   localparam int               PROD_W      = ACC_W + 32;

   localparam int OFF_W   = (BINS_PER_BAND > 1) ? $clog2(BINS_PER_BAND) : 1;
   localparam int BA_W    = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int HDEPTH  = BANDS * MAX_HISTORY;
   localparam int HA_W    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
   localparam int RING_W  = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int CMP_W   = ((RING_W > LEN_W) ? RING_W : LEN_W) + 1;
   // The history length register cannot exceed 127, which bounds the sums.
   localparam int LEN_MAX = (MAX_HISTORY < 127) ? MAX_HISTORY : 127;
   localparam int SUM_W   = MAG_W + $clog2(LEN_MAX);
   localparam int DVD_W   = SUM_W;
   localparam int DVR_W   = LEN_W;

   sbht_state_type state_ff, state_in;

   logic [LEN_W-1:0]      history_len_ff, history_len_in;
   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [LEN_W-1:0]      fill_ff, fill_in;
   logic [RING_W-1:0]     ring_ff, ring_in;
   logic [BANDS-1:0]      sum_valid_ff, sum_valid_in;

   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      band_ff, band_in;
   logic [HA_W-1:0]       slot_ff, slot_in;
   logic [MAG_W-1:0]      level_ff, level_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BAND_OUT_W-1:0] rsp_band_ff, rsp_band_in;
   logic [MAG_W-1:0]      rsp_level_ff, rsp_level_in;
   logic [MAG_W-1:0]      rsp_mean_ff, rsp_mean_in;
   logic                  rsp_done_ff, rsp_done_in;

   // Memory and divider hookup.
   logic                  hist_wr_en, hist_rd_en;
   logic [MAG_W-1:0]      hist_rd_data;
   logic                  sums_wr_en, sums_rd_en;
   logic [SUM_W-1:0]      sums_wr_data, sums_rd_data;
   logic                  div_start, div_busy;
   logic [DVD_W-1:0]      div_dividend, div_quotient;
   logic [DVR_W-1:0]      div_divisor;

   // Working values.
   logic                  csr_write;
   logic                  in_accept;
   logic                  out_free;
   logic [LEN_W-1:0]      len_eff;
   logic [RING_W-1:0]     ring_eff;
   logic [RING_W-1:0]     ring_next;
   logic [OFF_W-1:0]      offset;
   logic [ACC_W-1:0]      mag_ext;
   logic [BA_W-1:0]       band_sel;
   logic                  band_in_range;
   logic                  band_end;
   logic                  last_band;
   logic                  filling;
   logic [LEN_W-1:0]      count;
   logic [SUM_W-1:0]      sum_old;
   logic [SUM_W-1:0]      slot_old;
   logic [SUM_W-1:0]      sum_base;
   logic [PROD_W-1:0]     level_prod;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_HISTORY_LEN)
                       ? CSR_DATA_W'(history_len_ff) : '0;

   assign req_stall = (state_ff != ST_IDLE);
   assign in_accept = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // A length of zero acts as one; anything above the ring depth is clamped.
   always_comb begin
      if (history_len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(history_len_ff) > MAX_HISTORY) begin
         len_eff = LEN_W'(MAX_HISTORY);
      end else begin
         len_eff = history_len_ff;
      end
   end

   // The ring slot is always below the length in practice, since a length
   // change restarts it, but an out-of-range slot still falls back to zero.
   always_comb begin
      ring_eff = ring_ff;
      if (CMP_W'(ring_ff) >= CMP_W'(len_eff)) begin
         ring_eff = '0;
      end
      ring_next = ring_eff + RING_W'(1);
      if (CMP_W'(ring_eff) + CMP_W'(1) == CMP_W'(len_eff)) begin
         ring_next = '0;
      end
   end

   assign band_sel      = band_ff[BA_W-1:0];
   assign band_in_range = (32'(band_ff) < BANDS);
   assign last_band     = (32'(band_ff) == BANDS - 1);
   assign offset        = OFF_W'(32'(idx_ff) - 32'(band_ff) * BINS_PER_BAND);
   assign band_end      = (offset == OFF_W'(BINS_PER_BAND - 1)) && band_in_range;
   assign mag_ext       = (idx_ff == '0) ? '0 : ACC_W'(mag_ff);
   assign level_prod    = PROD_W'(acc_ff) * PROD_W'(LEVEL_RECIP);

   // Running-sum update for the band being closed. Until the history has
   // filled, the new level only adds; afterwards the level leaving the ring
   // is taken out first, never driving the sum below zero.
   assign filling  = (fill_ff < len_eff);
   assign count    = filling ? (fill_ff + LEN_W'(1)) : len_eff;
   assign sum_old  = sum_valid_ff[band_sel] ? sums_rd_data : '0;
   assign slot_old = SUM_W'(hist_rd_data);
   always_comb begin
      if (filling) begin
         sum_base = sum_old;
      end else if (sum_old >= slot_old) begin
         sum_base = sum_old - slot_old;
      end else begin
         sum_base = '0;
      end
   end
   assign sums_wr_data = sum_base + SUM_W'(level_ff);

   always_comb begin
      state_in       = state_ff;
      history_len_in = history_len_ff;
      acc_in         = acc_ff;
      fill_in        = fill_ff;
      ring_in        = ring_ff;
      sum_valid_in   = sum_valid_ff;
      mag_in         = mag_ff;
      idx_in         = idx_ff;
      band_in        = band_ff;
      slot_in        = slot_ff;
      level_in       = level_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_band_in    = rsp_band_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_done_in    = rsp_done_ff;
      hist_rd_en     = 1'b0;
      hist_wr_en     = 1'b0;
      sums_rd_en     = 1'b0;
      sums_wr_en     = 1'b0;
      div_start      = 1'b0;
      div_dividend   = '0;
      div_divisor    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_accept) begin
               mag_in   = req_bin_magnitude;
               idx_in   = req_bin_index;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            band_in  = IDX_W'((32'(idx_ff) * RECIP) >> RECIP_SHIFT);
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            // The first bin of a band restarts the accumulator.
            if (offset == '0) begin
               acc_in = mag_ext;
            end else begin
               acc_in = acc_ff + mag_ext;
            end
            if (band_end) begin
               // Fetch the band's sum and its outgoing ring entry while the
               // level is being formed.
               slot_in    = HA_W'(32'(band_sel) * MAX_HISTORY + 32'(ring_eff));
               hist_rd_en = 1'b1;
               sums_rd_en = 1'b1;
               state_in   = ST_DIV_LEVEL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV_LEVEL: begin
            level_in = level_prod[LEVEL_SHIFT +: MAG_W];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            hist_wr_en             = 1'b1;
            sums_wr_en             = 1'b1;
            sum_valid_in[band_sel] = 1'b1;
            div_start              = 1'b1;
            div_dividend           = DVD_W'(sums_wr_data);
            div_divisor            = count;
            state_in               = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            if (!div_busy && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_band_in  = band_ff[BAND_OUT_W-1:0];
               rsp_level_in = level_ff;
               rsp_mean_in  = div_quotient[MAG_W-1:0];
               rsp_done_in  = last_band;
               // The ring slot and fill count are shared by all bands and
               // move on once the frame's last band is done.
               if (last_band) begin
                  ring_in = ring_next;
                  fill_in = count;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Any write of the length restarts the history; the accumulator stays.
      if (csr_write && csr_paddr[2] == CSR_IDX_HISTORY_LEN) begin
         history_len_in = csr_pwdata[LEN_W-1:0];
         fill_in        = '0;
         ring_in        = '0;
         sum_valid_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         history_len_ff <= HISTORY_LEN_RESET;
         acc_ff         <= '0;
         fill_ff        <= '0;
         ring_ff        <= '0;
         sum_valid_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         history_len_ff <= history_len_in;
         acc_ff         <= acc_in;
         fill_ff        <= fill_in;
         ring_ff        <= ring_in;
         sum_valid_ff   <= sum_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      mag_ff       <= mag_in;
      idx_ff       <= idx_in;
      band_ff      <= band_in;
      slot_ff      <= slot_in;
      level_ff     <= level_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_level_ff <= rsp_level_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_done_ff  <= rsp_done_in;
   end

   // History ring of every band, one row of MAX_HISTORY levels per band.
   sbht_ram #(
      .WIDTH (MAG_W),
      .DEPTH (HDEPTH)
   ) u_history_ram (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (slot_ff),
      .wr_data (level_ff),
      .rd_en   (hist_rd_en),
      .rd_addr (slot_in),
      .rd_data (hist_rd_data)
   );

   // Running sum of each band's ring.
   sbht_ram #(
      .WIDTH (SUM_W),
      .DEPTH (BANDS)
   ) u_sums_ram (
      .clock   (clock),
      .wr_en   (sums_wr_en),
      .wr_addr (band_sel),
      .wr_data (sums_wr_data),
      .rd_en   (sums_rd_en),
      .rd_addr (band_sel),
      .rd_data (sums_rd_data)
   );

   // Serial divider for the history mean, the sum over the current count.
   sbht_divider #(
      .DVD_W (DVD_W),
      .DVR_W (DVR_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_band_index   = rsp_band_ff;
   assign rsp_band_level   = rsp_level_ff;
   assign rsp_history_mean = rsp_mean_ff;
   assign rsp_frame_done   = rsp_done_ff;

endmodule

@@ sv/sbht_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; read data is registered and holds its
// value while no read is requested.
// ----------------------------------------------------------------------------
module sbht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/sbht_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division, one quotient bit per cycle; the quotient holds after
// busy falls until the next start.
// ----------------------------------------------------------------------------
module sbht_divider
   import sbht_pkg::*;
#(
   parameter int DVD_W = 32,
   parameter int DVR_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVR_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVR_W-1:0] rem_ff, rem_in;
   logic [DVR_W-1:0] dvr_ff, dvr_in;
   logic [DVR_W:0]   shifted;
   logic [DVR_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvr_in  = dvr_ff;
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvr_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits DVR_W bits.
         if (!diff[DVR_W]) begin
            rem_in = diff[DVR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DVR_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvr_ff <= dvr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ dv/tb_spectral_band_history_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral band history tracker testbench
// Streams FFT bin words into the block, predicts each band result word from a
// behavioral copy of the band accumulator, history rings and running sums,
// and checks every result word in order. The history length register is
// reprogrammed between phases, and both channels see random idle cycles and
// one long result hold-off.
// ----------------------------------------------------------------------------
module tb_spectral_band_history_tracker;
   import sbht_pkg::*;

   localparam int BANDS         = 128;
   localparam int BINS_PER_BAND = 4;
   localparam int MAX_HISTORY   = 64;

   // This margin covers a closing bin's path to its result word before any
   // register write and at the end of the run.
   localparam int SETTLE_CYCLES = 80;
   localparam int HOLD_CYCLES   = 400;

   localparam logic [CSR_ADDR_W-1:0] HIST_LEN_ADDR = CSR_ADDR_W'(4 * CSR_IDX_HISTORY_LEN);
   localparam logic [MAG_W-1:0]      MAG_MAX       = {MAG_W{1'b1}};

   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic [IDX_W-1:0] index;
   } bin_word_type;

   typedef struct packed {
      logic [BAND_OUT_W-1:0] band_index;
      logic [MAG_W-1:0]      band_level;
      logic [MAG_W-1:0]      history_mean;
      logic                  frame_done;
   } band_result_type;

   // Every block input has a known value from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [MAG_W-1:0]      req_bin_magnitude = '0;
   logic [IDX_W-1:0]      req_bin_index = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BAND_OUT_W-1:0] rsp_band_index;
   logic [MAG_W-1:0]      rsp_band_level;
   logic [MAG_W-1:0]      rsp_history_mean;
   logic                  rsp_frame_done;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   spectral_band_history_tracker #(
      .BANDS         (BANDS),
      .BINS_PER_BAND (BINS_PER_BAND),
      .MAX_HISTORY   (MAX_HISTORY)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_bin_magnitude (req_bin_magnitude),
      .req_bin_index     (req_bin_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_band_index    (rsp_band_index),
      .rsp_band_level    (rsp_band_level),
      .rsp_history_mean  (rsp_history_mean),
      .rsp_frame_done    (rsp_frame_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #6 clock = ~clock;

   // Shared testbench state.
   bin_word_type    bin_q[$];            // bin words waiting for the driver
   band_result_type band_results_due[$]; // predicted result words, oldest first
   int              mismatches = 0;
   int              idle_pct = 0;        // chance per cycle of starting an idle burst
   int              gap_left = 0;
   int              stall_left = 0;
   bit              pressure_go = 1'b0;
   logic            pressure_hold = 1'b0;

   // Predictor state: a behavioral copy of the block's history bookkeeping.
   int                act_len = 43;   // history length after clamping to 1..64
   logic [ACC_W-1:0]  band_acc = '0;
   logic [MAG_W-1:0]  level_ring [BANDS*MAX_HISTORY];
   logic [30:0]       band_total [BANDS];
   int                frames_filled = 0;
   int                ring_slot = 0;

   // Stimulus-side shadow: which ring slots have ever been written, so that a
   // band is only closed when the slot it will retire holds a real level.
   bit                slot_written [BANDS*MAX_HISTORY];
   int                gen_frames = 0;
   int                gen_len = 43;
   int                band_pool [4] = '{0, 1, 64, 126};

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Accumulates one accepted bin word and, when it closes a band, computes the
   // band level, retires the oldest history slot once the ring is full, and
   // queues the result word the block must produce.
   task automatic track_bin(input logic [MAG_W-1:0] mag, input logic [IDX_W-1:0] idx);
      int unsigned      band;
      int unsigned      slot;
      int unsigned      count;
      logic [MAG_W-1:0] level;
      logic [MAG_W-1:0] stale;
      band_result_type  res;
      band = idx / BINS_PER_BAND;
      // The DC bin contributes nothing whatever its magnitude.
      if (idx == 0)
         mag = '0;
      if (idx % BINS_PER_BAND == 0)
         band_acc = ACC_W'(mag);
      else
         band_acc = band_acc + ACC_W'(mag);
      // With a 9-bit index every band number is below BANDS, so only the bin
      // position decides whether a result word follows.
      if (idx % BINS_PER_BAND != BINS_PER_BAND - 1 || band >= BANDS)
         return;
      level = MAG_W'(band_acc / BINS_PER_BAND);
      if (ring_slot >= act_len)
         ring_slot = 0;
      slot = band * MAX_HISTORY + ring_slot;
      if (frames_filled < act_len) begin
         count = frames_filled + 1;
      end else begin
         count = act_len;
         stale = level_ring[slot];
         // A stale slot from a skipped frame can exceed the running sum.
         if (band_total[band] >= 31'(stale))
            band_total[band] = band_total[band] - 31'(stale);
         else
            band_total[band] = '0;
      end
      band_total[band] = band_total[band] + 31'(level);
      level_ring[slot] = level;
      res.band_index   = BAND_OUT_W'(band);
      res.band_level   = level;
      res.history_mean = MAG_W'(band_total[band] / count);
      res.frame_done   = (band == BANDS - 1);
      band_results_due = {band_results_due, res};
      if (band == BANDS - 1) begin
         ring_slot = (ring_slot + 1) % act_len;
         if (frames_filled < act_len)
            frames_filled++;
      end
   endtask

   function automatic bit may_close(input int band);
      return gen_frames < gen_len ||
             slot_written[band * MAX_HISTORY + gen_frames % gen_len];
   endfunction

   // Queues one bin word. A closing bin whose retired slot was never written
   // is moved back one position so it leaves the band open instead.
   task automatic queue_bin(input logic [MAG_W-1:0] mag, input logic [IDX_W-1:0] idx);
      int band;
      bin_word_type w;
      band = idx / BINS_PER_BAND;
      if (idx % BINS_PER_BAND == BINS_PER_BAND - 1) begin
         if (!may_close(band)) begin
            idx = idx - IDX_W'(1);
         end else begin
            slot_written[band * MAX_HISTORY + gen_frames % gen_len] = 1'b1;
            if (band == BANDS - 1)
               gen_frames++;
         end
      end
      w.magnitude = mag;
      w.index = idx;
      bin_q = {bin_q, w};
   endtask

   function automatic logic [MAG_W-1:0] pick_mag();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return MAG_MAX;
         2: return MAG_W'($urandom_range(0, 255));
         default: return MAG_W'($urandom);
      endcase
   endfunction

   function automatic int pick_band();
      if ($urandom_range(0, 9) < 7)
         return band_pool[$urandom_range(0, 3)];
      return $urandom_range(0, BANDS - 1);
   endfunction

   task automatic queue_band(input int band, input int first_pos, input int last_pos);
      for (int p = first_pos; p <= last_pos; p++)
         queue_bin(pick_mag(), IDX_W'(band * BINS_PER_BAND + p));
   endtask

   // Mostly complete bands in order; the rest start late, stop early, or are
   // single stray bins anywhere in the frame.
   task automatic queue_burst();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind < 7)
         queue_band(pick_band(), 0, BINS_PER_BAND - 1);
      else if (kind == 7)
         queue_band(pick_band(), $urandom_range(1, BINS_PER_BAND - 1), BINS_PER_BAND - 1);
      else if (kind == 8)
         queue_band(pick_band(), 0, $urandom_range(0, BINS_PER_BAND - 2));
      else
         queue_bin(pick_mag(), IDX_W'($urandom_range(0, 2**IDX_W - 1)));
   endtask

   task automatic csr_access(input bit is_write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= HIST_LEN_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      // The transfer completes at this edge; prdata is sampled before it.
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Returns once every queued bin word is taken and every result word has
   // arrived, plus enough cycles for a bin that closes nothing to finish.
   task automatic wait_drained();
      while (bin_q.size() != 0 || req_valid || band_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Any write restarts the history in the block, so the predictor and the
   // stimulus shadow restart with it; the band accumulator carries over.
   task automatic set_history_len(input logic [LEN_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      wait_drained();
      csr_access(1'b1, CSR_DATA_W'(value), rd);
      act_len = (value == 0) ? 1 : (value > MAX_HISTORY) ? MAX_HISTORY : int'(value);
      frames_filled = 0;
      ring_slot = 0;
      foreach (band_total[b])
         band_total[b] = '0;
      gen_len = act_len;
      gen_frames = 0;
      csr_access(1'b0, '0, rd);
      if (rd != CSR_DATA_W'(value))
         report_mismatch("history_len read back", rd, CSR_DATA_W'(value));
   endtask

   task automatic run_phase(input logic [LEN_W-1:0] len_value, input int frames,
                            input int extra_max, input int idle, input bit squeeze);
      int n;
      set_history_len(len_value);
      idle_pct = idle;
      for (int f = 0; f < frames; f++) begin
         n = $urandom_range(0, extra_max) + int'($urandom_range(0, 7) == 0);
         repeat (n) queue_burst();
         // Band BANDS-1 closes the frame and advances the shared ring slot.
         queue_band(BANDS - 1, 0, BINS_PER_BAND - 1);
      end
      if (squeeze)
         pressure_go = 1'b1;
   endtask

   // Input driver: holds each bin word until taken, feeds the predictor on the
   // accepting edge, and inserts random idle bursts between words.
   always @(posedge clock) begin : bin_driver
      bin_word_type next_bin;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            track_bin(req_bin_magnitude, req_bin_index);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
               gap_left = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (bin_q.size() != 0) begin
               next_bin = bin_q.pop_front();
               req_valid         <= 1'b1;
               req_bin_magnitude <= next_bin.magnitude;
               req_bin_index     <= next_bin.index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted result word against the oldest
   // prediction and drives random stall bursts, plus the long hold-off.
   always @(posedge clock) begin : result_monitor
      band_result_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (band_results_due.size() == 0) begin
               report_mismatch("result word with none pending, band",
                               32'(rsp_band_index), '0);
            end else begin
               due = band_results_due.pop_front();
               if (rsp_band_index !== due.band_index)
                  report_mismatch("band_index", 32'(rsp_band_index),
                                  32'(due.band_index));
               if (rsp_band_level !== due.band_level)
                  report_mismatch("band_level", 32'(rsp_band_level),
                                  32'(due.band_level));
               if (rsp_history_mean !== due.history_mean)
                  report_mismatch("history_mean", 32'(rsp_history_mean),
                                  32'(due.history_mean));
               if (rsp_frame_done !== due.frame_done)
                  report_mismatch("frame_done", 32'(rsp_frame_done),
                                  32'(due.frame_done));
            end
         end
         if (stall_left > 0)
            stall_left--;
         else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            stall_left = $urandom_range(1, 7);
         rsp_stall <= pressure_hold || (stall_left > 0);
      end
   end

   // Long receiver hold-off while the sender keeps offering bin words, so the
   // block backs up and stalls its input.
   initial begin
      wait (pressure_go);
      @(posedge clock);
      pressure_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      pressure_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [CSR_DATA_W-1:0] rd;
      foreach (band_total[b])
         band_total[b] = '0;
      band_pool[2] = $urandom_range(2, BANDS - 3);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      csr_access(1'b0, '0, rd);
      if (rd != CSR_DATA_W'(HISTORY_LEN_RESET))
         report_mismatch("history_len after reset", rd, CSR_DATA_W'(HISTORY_LEN_RESET));

      // Directed part under the reset length. Band 0 carries a full-scale DC
      // bin that must count as zero; band 2 is all full scale, the largest
      // level there is; band 3 arrives without its first bins, so the
      // accumulator continues from band 2 and wraps at 27 bits.
      idle_pct = 0;
      for (int p = 0; p < BINS_PER_BAND; p++)
         queue_bin(MAG_MAX, IDX_W'(p));
      for (int p = 0; p < BINS_PER_BAND; p++)
         queue_bin(MAG_MAX, IDX_W'(2 * BINS_PER_BAND + p));
      queue_bin(MAG_MAX, IDX_W'(3 * BINS_PER_BAND + 1));
      queue_bin(MAG_MAX, IDX_W'(3 * BINS_PER_BAND + 3));
      queue_band(BANDS - 1, 0, BINS_PER_BAND - 1);
      // Band 5 is left half done across a register write: the accumulator must
      // survive the history restart.
      queue_bin(MAG_MAX, IDX_W'(5 * BINS_PER_BAND));
      queue_bin(MAG_W'(1), IDX_W'(5 * BINS_PER_BAND + 1));

      // A length of zero behaves as one, so the mean is always the new level.
      set_history_len('0);
      queue_bin(MAG_MAX, IDX_W'(5 * BINS_PER_BAND + 2));
      queue_bin(MAG_MAX, IDX_W'(5 * BINS_PER_BAND + 3));
      queue_band(BANDS - 1, 0, BINS_PER_BAND - 1);
      queue_band(BANDS - 1, 0, BINS_PER_BAND - 1);

      // Random phases. The first phase, at length 64, runs past a full ring so the
      // oldest level is retired, and carries the long hold-off. The last phase runs
      // without idle cycles.
      run_phase(7'd64, MAX_HISTORY + 2, 0, 15, 1'b1);
      run_phase(7'd127, 4, 3, 20, 1'b0);
      run_phase(LEN_W'($urandom_range(2, 9)), 8, 3, 25, 1'b0);
      run_phase(7'd1, 5, 3, 10, 1'b0);
      run_phase(LEN_W'($urandom_range(2, 12)), 8, 3, 0, 1'b0);

      wait_drained();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ spectral_band_history_tracker.f @@
sv/sbht_pkg.sv
sv/sbht_ram.sv
sv/sbht_divider.sv
sv/spectral_band_history_tracker.sv
dv/tb_spectral_band_history_tracker.sv
